### design/xwbd_pkg.sv
// ----------------------------------------------------------------------------
// xwbd_pkg
// Shared types, constants and helpers of the wide XTEA block decryptor.
// ----------------------------------------------------------------------------
package xwbd_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned Rounds  = 32;
  localparam int unsigned NStages = 2 * Rounds;   // one half-round per stage
  localparam int unsigned KeyNum  = 4;
  localparam int unsigned KeyIdxW = $clog2(KeyNum);
  localparam int unsigned CfgIdxW = KeyIdxW;

  localparam logic [WordW-1:0] Delta     = 64'h0000_0000_9E37_79B9;
  localparam int unsigned      ShiftUp   = 4;
  localparam int unsigned      ShiftDown = 5;
  localparam int unsigned      SumSelLo  = 11;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_W0 = 2'd0,
    CFG_KEY_W1 = 2'd1,
    CFG_KEY_W2 = 2'd2,
    CFG_KEY_W3 = 2'd3
  } cfg_idx_e;

  typedef logic [KeyNum-1:0][WordW-1:0] key_arr_t;

  typedef struct packed {
    logic [WordW-1:0] left;
    logic [WordW-1:0] right;
  } half_t;

  // Running sum seen by a pipeline stage: even stages use the sum of the round
  // start, odd stages the sum after the drop by one delta.
  function automatic logic [WordW-1:0] stage_sum(input int unsigned stage);
    logic [WordW-1:0] rnd;
    logic [WordW-1:0] left_rounds;
    rnd         = WordW'(stage >> 1);
    left_rounds = WordW'(Rounds) - rnd;
    if (stage[0]) begin
      left_rounds = left_rounds - WordW'(1);
    end
    return Delta * left_rounds;
  endfunction

endpackage

### design/xwbd_stage.sv
// ----------------------------------------------------------------------------
// xwbd_stage
// One registered half-round: reduce one half by the mixed other half.
// ----------------------------------------------------------------------------
module xwbd_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        upd_right_i,
  input  logic [xwbd_pkg::WordW-1:0]  sum_i,
  input  xwbd_pkg::key_arr_t          keys_i,
  input  logic                        valid_i,
  input  xwbd_pkg::half_t             data_i,
  output logic                        valid_o,
  output xwbd_pkg::half_t             data_o
);
  import xwbd_pkg::*;

  logic                valid_q;
  half_t               data_q, data_d;
  logic [WordW-1:0]    src, dst, mix, key_sum, delta_w;
  logic [KeyIdxW-1:0]  kidx;

  always_comb begin
    src     = upd_right_i ? data_i.left : data_i.right;
    dst     = upd_right_i ? data_i.right : data_i.left;
    kidx    = upd_right_i ? sum_i[SumSelLo +: KeyIdxW] : sum_i[KeyIdxW-1:0];
    mix     = ((src << ShiftUp) ^ (src >> ShiftDown)) + src;
    key_sum = sum_i + keys_i[kidx];
    delta_w = dst - (mix ^ key_sum);
    data_d  = data_i;
    if (upd_right_i) begin
      data_d.right = delta_w;
    end else begin
      data_d.left = delta_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### design/xtea_wide_block_decrypt.sv
// ----------------------------------------------------------------------------
// xtea_wide_block_decrypt
// Fully unrolled XTEA-style decryptor on 64-bit words, 128-bit blocks.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------
//   in      | sink      | in_valid_i / in_stall_o | cipher_left_i, cipher_right_i
//   out     | source    | out_valid_o / out_stall_i | plain_left_o, plain_right_o
//   cfg     | sink      | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// Throughput: one block enters per cycle unless in_stall_o is high; each
//   half-round is one registered stage, the last doubling as output register.
// Each stage holds one subtract after a parallel mix add and key-sum add.
// Reset: clears all stage valid bits and the four key words to zero.
// Stalls: the whole pipe freezes while a result is held at the output, so
//   no transfer is dropped or repeated; bubbles advance otherwise.
// ----------------------------------------------------------------------------
module xtea_wide_block_decrypt (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [xwbd_pkg::WordW-1:0]           cipher_left_i,
  input  logic [xwbd_pkg::WordW-1:0]           cipher_right_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [xwbd_pkg::WordW-1:0]           plain_left_o,
  output logic [xwbd_pkg::WordW-1:0]           plain_right_o,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [xwbd_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [xwbd_pkg::WordW-1:0]           cfg_data_i
);
  import xwbd_pkg::*;

  key_arr_t keys_q;

  // Key registers: write whole word at the chosen index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_KEY_W0: keys_q[0] <= cfg_data_i;
        CFG_KEY_W1: keys_q[1] <= cfg_data_i;
        CFG_KEY_W2: keys_q[2] <= cfg_data_i;
        CFG_KEY_W3: keys_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline chain: element 0 is the input side, element NStages the output
  logic  [NStages:0] vld;
  half_t             dat [NStages+1];
  logic              adv;

  // Advance everything unless a finished block waits at the output.
  assign adv        = !(vld[NStages] && out_stall_i);
  assign in_stall_o = !adv;

  assign vld[0]     = in_valid_i;
  assign dat[0]     = '{left: cipher_left_i, right: cipher_right_i};

  for (genvar s = 0; s < NStages; s++) begin : g_stage
    // Even stages reduce the right half, odd stages the left half.
    localparam logic [WordW-1:0] StageSum = stage_sum(s);
    localparam logic             UpdRight = ((s % 2) == 0);

    xwbd_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (adv),
      .upd_right_i (UpdRight),
      .sum_i       (StageSum),
      .keys_i      (keys_q),
      .valid_i     (vld[s]),
      .data_i      (dat[s]),
      .valid_o     (vld[s+1]),
      .data_o      (dat[s+1])
    );
  end

  assign out_valid_o   = vld[NStages];
  assign plain_left_o  = dat[NStages].left;
  assign plain_right_o = dat[NStages].right;

endmodule

### design/xwbd_checker.sv
// ----------------------------------------------------------------------------
// xwbd_checker
// Port-level checks of the wide XTEA block decryptor, bound to the top level.
// ----------------------------------------------------------------------------
module xwbd_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_stall_o,
  input  logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  input  logic [xwbd_pkg::WordW-1:0]           plain_left_o,
  input  logic [xwbd_pkg::WordW-1:0]           plain_right_o
);
  import xwbd_pkg::*;

  // Hold a pending result until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(plain_left_o) && $stable(plain_right_o))
    else $error("stalled result changed");

  // Input backpressure only comes from a held result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output free");

  // Pipe is empty right after reset.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result shown right after reset");

endmodule

bind xtea_wide_block_decrypt xwbd_checker u_xwbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .plain_left_o  (plain_left_o),
  .plain_right_o (plain_right_o)
);
